[design/bcrl_pkg.sv]
// Shared types and constants for the bucket connection rate limiter.
// Holds the word formats, register indexes, verdict codes and the control
// and status groups between the controller and the datapath; no dependencies.
package bcrl_pkg;

    // Fixed field widths.
    localparam int BUCKET_W  = 13;
    localparam int BUCKET_SPAN = 8192;
    localparam int CNT_W     = 17;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEPT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSPEND_CYCLES = 2'd2;

    // Configuration reset values.
    localparam logic             RST_LIMIT_ENABLE   = 1'b0;
    localparam logic [CFG_W-1:0] RST_MAX_ACCEPT     = 16'd16;
    localparam logic [CFG_W-1:0] RST_SUSPEND_CYCLES = 16'd4;

    // Input opcodes.
    localparam logic OP_ATTEMPT = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Verdict codes.
    localparam logic [1:0] V_ACCEPT  = 2'd0;
    localparam logic [1:0] V_LOCKED  = 2'd1;
    localparam logic [1:0] V_NEWLOCK = 2'd2;
    localparam logic [1:0] V_TICK    = 2'd3;

    // Read address sources for the counter memory.
    typedef logic [1:0] t_rd_src;
    localparam t_rd_src RD_ZERO = 2'd0;
    localparam t_rd_src RD_IN   = 2'd1;
    localparam t_rd_src RD_REM  = 2'd2;
    localparam t_rd_src RD_NEXT = 2'd3;

    typedef struct packed {
        logic                opcode;
        logic [BUCKET_W-1:0] bucket;
    } t_in_word;

    typedef struct packed {
        logic [1:0] verdict;
        logic       accepted;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        t_rd_src rd_src;
        logic    mod_step;
        logic    cnt_clr;
        logic    cnt_inc;
        logic    clear_wr;
        logic    sweep_wr;
        logic    eval;
        logic    tick_done;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic idx_direct;
        logic mod_done;
        logic cnt_last;
    } t_dp_sts;

endpackage

[design/bucket_connection_rate_limiter.sv]
// Top level of the bucket connection rate limiter.
// Joins the controller bcrl_ctrl and the datapath bcrl_dpath; uses bcrl_pkg.
//
// Each word taken on i_word is either a connection attempt that names a
// source bucket or a period tick. A word is taken at a rising edge where
// i_start is high and o_busy is low, and exactly one result word follows on
// o_word, shown for a single cycle with o_valid high; the receiver cannot
// hold it off, so it must capture the word in that cycle. o_busy stays high
// while a word is in work, so no new word is taken before its result. The
// bucket index is a plain cast when BUCKETS is a power of two or at least
// 8192; for any other bucket count the bucket index is reduced by a
// reciprocal multiplication and one correcting subtraction in two steps.
// A tick walks the single-port-write counter memory one bucket a cycle.
// After reset the block clears its counter memory in a pass over all
// BUCKETS entries with o_busy high; configuration writes on i_cfg_we are
// taken at any time, including during that pass, but are meant to be made
// only while no word is in work.
module bucket_connection_rate_limiter #(
    parameter int BUCKETS = 8192
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  bcrl_pkg::t_in_word            i_word,
    output logic                          o_valid,
    output bcrl_pkg::t_out_word           o_word,
    input  logic                          i_cfg_we,
    input  logic [bcrl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bcrl_pkg::CFG_W-1:0]    i_cfg_data
);
    import bcrl_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // The controller owns the handshake and the result strobe.
    bcrl_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_opcode (i_word.opcode),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .o_busy   (o_busy),
        .o_valid  (o_valid)
    );

    // The datapath holds the per-bucket counters and the result payload.
    bcrl_dpath #(
        .BUCKETS (BUCKETS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_word     (i_word),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_word     (o_word)
    );

endmodule

[design/bcrl_ctrl.sv]
// Controller state machine of the bucket connection rate limiter.
// Sequences the clearing pass, attempt lookups and tick sweeps; uses bcrl_pkg.
module bcrl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_opcode,
    input  bcrl_pkg::t_dp_sts i_sts,
    output bcrl_pkg::t_dp_cmd o_cmd,
    output logic              o_busy,
    output logic              o_valid
);
    import bcrl_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MOD   = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_SWEEP = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_valid;
    t_dp_cmd    w_cmd;

    always_comb begin
        n_state = r_state;
        w_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                w_cmd.clear_wr = 1'b1;
                w_cmd.cnt_inc  = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                w_cmd.cnt_clr = 1'b1;
                if (i_start) begin
                    w_cmd.capture = 1'b1;
                    if (i_opcode == OP_TICK) begin
                        w_cmd.rd_src = RD_ZERO;
                        n_state      = ST_SWEEP;
                    end else begin
                        w_cmd.rd_src = RD_IN;
                        n_state      = i_sts.idx_direct ? ST_EVAL : ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                if (i_sts.mod_done) begin
                    w_cmd.rd_src = RD_REM;
                    n_state      = ST_EVAL;
                end else begin
                    w_cmd.mod_step = 1'b1;
                end
            end
            ST_EVAL: begin
                w_cmd.eval = 1'b1;
                n_state    = ST_IDLE;
            end
            ST_SWEEP: begin
                w_cmd.sweep_wr = 1'b1;
                w_cmd.cnt_inc  = 1'b1;
                w_cmd.rd_src   = RD_NEXT;
                if (i_sts.cnt_last) begin
                    w_cmd.tick_done = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= w_cmd.eval | w_cmd.tick_done;
        end
    end

    assign o_cmd   = w_cmd;
    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = r_valid;

endmodule

[design/bcrl_dpath.sv]
// Datapath of the bucket connection rate limiter: configuration registers,
// the bucket counter memory, the index reduction unit and the verdict logic.
// Uses bcrl_pkg; driven by bcrl_ctrl.
module bcrl_dpath #(
    parameter int BUCKETS = 8192
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bcrl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bcrl_pkg::CFG_W-1:0]    i_cfg_data,
    input  bcrl_pkg::t_in_word            i_word,
    input  bcrl_pkg::t_dp_cmd             i_cmd,
    output bcrl_pkg::t_dp_sts             o_sts,
    output bcrl_pkg::t_out_word           o_word
);
    import bcrl_pkg::*;

    localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam bit REM_NEEDED = (BUCKETS < BUCKET_SPAN) &&
                                ((BUCKETS & (BUCKETS - 1)) != 0);

    logic             r_limit_en;
    logic [CFG_W-1:0] r_max_accept;
    logic [CFG_W-1:0] r_suspend;

    logic [CNT_W-1:0] r_mem [BUCKETS];
    logic [CNT_W-1:0] r_rd_data;
    logic [IDX_W-1:0] r_cnt;
    logic [IDX_W-1:0] w_rd_addr;
    logic [IDX_W-1:0] w_wr_addr;
    logic [CNT_W-1:0] w_wr_data;
    logic             w_wr_en;
    logic [IDX_W-1:0] w_idx;
    logic             w_mod_done;

    logic             w_locked;
    logic [CNT_W-1:0] w_next;
    logic             w_over;
    t_out_word        w_verdict;
    logic             w_upd;
    logic [CNT_W-1:0] w_upd_val;
    logic [CNT_W-1:0] w_tick_val;
    t_out_word        r_out;

    // Configuration registers; writes to an unused index are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_en   <= RST_LIMIT_ENABLE;
            r_max_accept <= RST_MAX_ACCEPT;
            r_suspend    <= RST_SUSPEND_CYCLES;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LIMIT_ENABLE:   r_limit_en   <= i_cfg_data[0];
                CFG_MAX_ACCEPT:     r_max_accept <= i_cfg_data;
                CFG_SUSPEND_CYCLES: r_suspend    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Bucket index: a plain cast where the bucket count divides the input
    // range evenly or covers it, otherwise a remainder found in two steps.
    generate
        if (REM_NEEDED) begin : g_rem
            // The reciprocal is rounded down, so the estimated quotient is the
            // true one or one short and a single compare and subtract fixes
            // the remainder. First step: quotient. Second step: remainder.
            localparam int RECIP = BUCKET_SPAN / BUCKETS;
            logic [BUCKET_W-1:0]   r_bucket;
            logic [BUCKET_W-1:0]   r_quot;
            logic [IDX_W-1:0]      r_rem;
            logic [1:0]            r_step;
            logic [2*BUCKET_W-1:0] w_prod;
            logic [BUCKET_W-1:0]   w_diff;
            logic [IDX_W-1:0]      w_rem;

            assign w_prod = {{BUCKET_W{1'b0}}, r_bucket} * (2*BUCKET_W)'(RECIP);
            assign w_diff = r_bucket - (r_quot * BUCKET_W'(BUCKETS));
            assign w_rem  = (w_diff >= BUCKET_W'(BUCKETS)) ?
                            IDX_W'(w_diff - BUCKET_W'(BUCKETS)) : IDX_W'(w_diff);

            always_ff @(posedge i_clk) begin
                if (i_cmd.capture) begin
                    r_bucket <= i_word.bucket;
                    r_step   <= '0;
                end else if (i_cmd.mod_step && !w_mod_done) begin
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd0) begin
                        r_quot <= w_prod[2*BUCKET_W-1:BUCKET_W];
                    end else begin
                        r_rem <= w_rem;
                    end
                end
            end

            assign w_mod_done = (r_step == 2'd2);
            assign w_idx      = r_rem;
        end else begin : g_direct
            logic [BUCKET_W-1:0] r_bucket;

            always_ff @(posedge i_clk) begin
                if (i_cmd.capture) begin
                    r_bucket <= i_word.bucket;
                end
            end

            assign w_mod_done = 1'b1;
            assign w_idx      = IDX_W'(r_bucket);
        end
    endgenerate

    // Sweep address counter, shared by the clearing pass and the tick sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt <= r_cnt + IDX_W'(1);
        end
    end

    always_comb begin
        case (i_cmd.rd_src)
            RD_IN:   w_rd_addr = IDX_W'(i_word.bucket);
            RD_REM:  w_rd_addr = w_idx;
            RD_NEXT: w_rd_addr = r_cnt + IDX_W'(1);
            default: w_rd_addr = '0;
        endcase
    end

    // Attempt evaluation on the counter just read.
    assign w_locked   = r_rd_data[CNT_W-1];
    assign w_next     = {1'b0, r_rd_data[CNT_W-2:0]} + CNT_W'(1);
    assign w_over     = (w_next > CNT_W'(r_max_accept));
    assign w_tick_val = w_locked ? (r_rd_data + CNT_W'(1)) : '0;

    always_comb begin
        w_upd     = 1'b0;
        w_upd_val = w_next;
        if (!r_limit_en) begin
            w_verdict = '{verdict: V_ACCEPT, accepted: 1'b1};
        end else if (w_locked) begin
            w_verdict = '{verdict: V_LOCKED, accepted: 1'b0};
        end else if (w_over) begin
            // A zero suspend length writes zero, which leaves the bucket open.
            w_verdict = '{verdict: V_NEWLOCK, accepted: 1'b0};
            w_upd     = 1'b1;
            w_upd_val = CNT_W'(0) - CNT_W'(r_suspend);
        end else begin
            w_verdict = '{verdict: V_ACCEPT, accepted: 1'b1};
            w_upd     = 1'b1;
        end
    end

    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_cnt;
        w_wr_data = '0;
        if (i_cmd.eval) begin
            w_wr_en   = w_upd;
            w_wr_addr = w_idx;
            w_wr_data = w_upd_val;
        end else if (i_cmd.sweep_wr) begin
            w_wr_en   = 1'b1;
            w_wr_data = w_tick_val;
        end else if (i_cmd.clear_wr) begin
            w_wr_en   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_out <= w_verdict;
        end else if (i_cmd.tick_done) begin
            r_out <= '{verdict: V_TICK, accepted: 1'b0};
        end
    end

    assign o_sts.idx_direct = !REM_NEEDED;
    assign o_sts.mod_done   = w_mod_done;
    assign o_sts.cnt_last   = (r_cnt == IDX_W'(BUCKETS - 1));
    assign o_word           = r_out;

endmodule

[design/bcrl_checker.sv]
// Port-level checker for the bucket connection rate limiter, with its bind.
// Uses bcrl_pkg; attaches to bucket_connection_rate_limiter.
module bcrl_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_start,
    input logic                o_busy,
    input logic                o_valid,
    input bcrl_pkg::t_out_word o_word
);
    import bcrl_pkg::*;

    // An accepted word keeps the block busy in the following cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("block not busy after accepting a word");

    // A result only ends a busy period and the block is free while it shows.
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_busy && $past(o_busy)))
        else $error("result strobe outside the end of a busy period");

    // One result per word: the strobe is never held high.
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // The accepted flag goes with the accept verdict and with nothing else.
    a_flag_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_word.accepted == (o_word.verdict == V_ACCEPT)))
        else $error("accepted flag disagrees with verdict");

endmodule

bind bucket_connection_rate_limiter bcrl_checker u_bcrl_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .o_busy  (o_busy),
    .o_valid (o_valid),
    .o_word  (o_word)
);
